[rtl/core/cfc_pkg.sv]
package cfc_pkg;

  // Weight averaging
  localparam int unsigned AVG_SAMPLES = 3;
  localparam int unsigned SAMPLE_MAX  = 16000;
  localparam int unsigned SUM_W       = $clog2(AVG_SAMPLES * SAMPLE_MAX + 1);
  localparam int unsigned CNT_W       = $clog2(AVG_SAMPLES + 1);
  // divide by AVG_SAMPLES as multiply by a rounded-up reciprocal, exact below 2**SUM_W
  localparam int unsigned RECIP_SH    = SUM_W + 3;
  localparam int unsigned RECIP       = ((2 ** RECIP_SH) + AVG_SAMPLES - 1) / AVG_SAMPLES;
  localparam int unsigned RECIP_W     = RECIP_SH + 1;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;

  localparam int unsigned WEIGHT_W  = 14;
  localparam int unsigned TICKS_W   = 10;
  localparam int unsigned PRESS_W   = 8;
  localparam int unsigned CFG_W     = 14;
  localparam int unsigned REPLY_MAX = 4;
  localparam int unsigned BEAT_W    = $clog2(REPLY_MAX);

  // input item codes
  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_SAMPLE = 3'd1,
    CMD_BOX    = 3'd2,
    CMD_PRESS  = 3'd3,
    CMD_PIN    = 3'd4,
    CMD_WRITE  = 3'd5,
    CMD_READ   = 3'd6
  } cmd_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_TARGET   = 2'd0,
    REG_BOX_DLY  = 2'd1,
    REG_TIMEOUT  = 2'd2,
    REG_DEBOUNCE = 2'd3
  } cfg_reg_e;

  // controller state, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MOVING = 5'b00010,
    ST_BOX    = 5'b00100,
    ST_WEIGH  = 5'b01000,
    ST_EMERG  = 5'b10000
  } ctrl_state_e;

  // state codes as reported
  localparam logic [2:0] CODE_IDLE   = 3'd0;
  localparam logic [2:0] CODE_MOVING = 3'd1;
  localparam logic [2:0] CODE_BOX    = 3'd2;
  localparam logic [2:0] CODE_WEIGH  = 3'd3;
  localparam logic [2:0] CODE_EMERG  = 3'd4;

  // i2c command bytes
  localparam logic [7:0] OP_GET_WEIGHT = 8'h57;  // 'W'
  localparam logic [7:0] OP_GET_STATE  = 8'h53;  // 'S'
  localparam logic [7:0] OP_START      = 8'h54;  // 'T'
  localparam logic [7:0] OP_STOP       = 8'h50;  // 'P'
  localparam logic [7:0] OP_EMERG      = 8'h45;  // 'E'
  localparam logic [7:0] REPLY_ACK     = 8'h01;
  localparam logic [7:0] REPLY_UNKNOWN = 8'hFF;

  // one result run handed to the reply stage
  typedef struct packed {
    logic [2:0]                  state_code;
    logic                        motor_on;
    logic                        servo_open;
    logic                        emergency_flag;
    logic [REPLY_MAX-1:0][7:0]   bytes;
    logic                        reply_valid;
    logic [BEAT_W-1:0]           last_idx;
  } reply_pkt_t;

  function automatic logic [2:0] state_code(ctrl_state_e st);
    logic [2:0] code;
    unique case (st)
      ST_IDLE:   code = CODE_IDLE;
      ST_MOVING: code = CODE_MOVING;
      ST_BOX:    code = CODE_BOX;
      ST_WEIGH:  code = CODE_WEIGH;
      ST_EMERG:  code = CODE_EMERG;
      default:   code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

[rtl/core/cfc_reply.sv]
module cfc_reply import cfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  reply_pkt_t pkt_i,
  output logic       ready_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] state_code_o,
  output logic       motor_on_o,
  output logic       servo_open_o,
  output logic       emergency_flag_o,
  output logic [7:0] reply_byte_o,
  output logic       reply_valid_o,
  output logic       reply_last_o
);

  reply_pkt_t        pkt_q;
  logic              pkt_valid_q;
  logic [BEAT_W-1:0] idx_q;
  logic              fire;
  logic              last;
  logic              done;

  assign fire    = pkt_valid_q && !out_stall_i;
  assign last    = (idx_q == pkt_q.last_idx);
  assign done    = fire && last;
  assign ready_o = !pkt_valid_q || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load_i) begin
      pkt_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (done) begin
      pkt_valid_q <= 1'b0;
    end else if (fire) begin
      idx_q <= idx_q + BEAT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pkt_q <= pkt_i;
    end
  end

  assign out_valid_o      = pkt_valid_q;
  assign state_code_o     = pkt_q.state_code;
  assign motor_on_o       = pkt_q.motor_on;
  assign servo_open_o     = pkt_q.servo_open;
  assign emergency_flag_o = pkt_q.emergency_flag;
  assign reply_byte_o     = pkt_q.bytes[idx_q];
  assign reply_valid_o    = pkt_q.reply_valid;
  assign reply_last_o     = last;

`ifndef SYNTHESIS
  a_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_valid_q |-> idx_q <= pkt_q.last_idx)
    else $error("reply beat index beyond run");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!pkt_valid_q || done))
    else $error("reply run overwritten before last beat");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !last && !load_i) |=> (pkt_valid_q && idx_q == $past(idx_q) + BEAT_W'(1)))
    else $error("reply run did not advance after a beat");
`endif

endmodule

[rtl/core/conveyor_fill_controller.sv]
// Conveyor fill-station controller. Each input beat is one event: a 50 ms tick, a
// load-cell sample, an IR box event, a start press, an emergency pin change, an
// i2c command write or an i2c read. The event is applied in the cycle it is
// accepted, and its results go to a reply register that drives the output
// channel. Every event except a read gives one result beat carrying the status
// after the event (reply_valid low, reply_last high). A read gives one to four
// beats with reply bytes chosen by the last written command byte: 'W' the
// average weight little-endian padded to four bytes, 'S' state, motor and
// emergency latch, 'T'/'P'/'E' 0x01, anything else 0xFF. Rate: one input beat
// per cycle while the reply register is free; it holds one run, so a read of n
// bytes stalls the input until its last beat has left, as does a stalled output,
// and the next beat is taken in the cycle the last reply beat leaves. Weights
// are grams times 16; samples outside 0..16000 are dropped, and every AVG_SAMPLES
// good ones update the average. Configuration writes are registered and must only
// be issued while the block is idle.
module conveyor_fill_controller import cfc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write port
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         cmd_i,
  input  logic [7:0]         data_byte_i,
  input  logic signed [15:0] weight_sample_i,
  input  logic               emerg_pin_pressed_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         state_code_o,
  output logic               motor_on_o,
  output logic               servo_open_o,
  output logic               emergency_flag_o,
  output logic [7:0]         reply_byte_o,
  output logic               reply_valid_o,
  output logic               reply_last_o
);

  // configuration
  logic [WEIGHT_W-1:0] target_q;
  logic [7:0]          box_dly_q;
  logic [TICKS_W-1:0]  timeout_q;
  logic [7:0]          debounce_q;

  // controller state
  ctrl_state_e         st_q, st_d;
  logic                motor_q, motor_d;
  logic                servo_q, servo_d;
  logic                latch_q, latch_d;
  logic                pin_q, pin_d;
  logic [TICKS_W-1:0]  ticks_q, ticks_d;
  logic [7:0]          last_cmd_q, last_cmd_d;
  logic                pend_q, pend_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [WEIGHT_W-1:0] avg_q, avg_d;
  logic [PRESS_W-1:0]  press_q, press_d;

  logic                ready;
  logic                accept;
  logic                sample_ok;
  logic [SUM_W-1:0]    sum_add;
  logic [CNT_W-1:0]    cnt_inc;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   quot;
  reply_pkt_t          pkt;

  assign accept     = in_valid_i && ready;
  assign in_stall_o = !ready;

  // sample range check and running sum; divide by AVG_SAMPLES via reciprocal
  assign sample_ok = !weight_sample_i[15] &&
                     (weight_sample_i[14:0] <= 15'(SAMPLE_MAX));
  assign sum_add   = sum_q + SUM_W'(weight_sample_i[13:0]);
  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign prod      = PROD_W'(sum_add) * PROD_W'(RECIP);
  assign quot      = prod >> RECIP_SH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= WEIGHT_W'(800);
      box_dly_q  <= 8'd20;
      timeout_q  <= TICKS_W'(200);
      debounce_q <= 8'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_TARGET:   target_q   <= cfg_data_i[WEIGHT_W-1:0];
        REG_BOX_DLY:  box_dly_q  <= cfg_data_i[7:0];
        REG_TIMEOUT:  timeout_q  <= cfg_data_i[TICKS_W-1:0];
        REG_DEBOUNCE: debounce_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    st_d       = st_q;
    motor_d    = motor_q;
    servo_d    = servo_q;
    latch_d    = latch_q;
    pin_d      = pin_q;
    ticks_d    = ticks_q;
    last_cmd_d = last_cmd_q;
    pend_d     = pend_q;
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    avg_d      = avg_q;
    press_d    = press_q;

    if (accept) begin
      unique case (cmd_e'(cmd_i))
        CMD_TICK: begin
          // pending i2c command runs first
          if (pend_q) begin
            pend_d = 1'b0;
            unique case (last_cmd_q)
              OP_START: begin
                if (st_d == ST_IDLE && !latch_d) st_d = ST_MOVING;
              end
              OP_STOP: begin
                if (st_d != ST_EMERG) begin
                  st_d    = ST_IDLE;
                  motor_d = 1'b0;
                end
              end
              OP_EMERG: begin
                latch_d = 1'b1;
                st_d    = ST_EMERG;
              end
              default: ;
            endcase
          end
          if (press_d != '1) press_d = press_d + PRESS_W'(1);
          unique case (st_d)
            ST_IDLE: begin
              motor_d = 1'b0;
              ticks_d = '0;
            end
            ST_MOVING: begin
              if (!latch_d) motor_d = 1'b1;
              ticks_d = '0;
            end
            ST_BOX: begin
              motor_d = 1'b0;
              if (ticks_d != '1) ticks_d = ticks_d + TICKS_W'(1);
              if (ticks_d >= TICKS_W'(box_dly_q)) begin
                servo_d = 1'b1;
                st_d    = ST_WEIGH;
                ticks_d = '0;
              end
            end
            ST_WEIGH: begin
              if (ticks_d != '1) ticks_d = ticks_d + TICKS_W'(1);
              if (avg_q >= target_q) begin
                servo_d = 1'b0;
                st_d    = ST_MOVING;
                ticks_d = '0;
              end else if (ticks_d >= timeout_q) begin
                servo_d = 1'b0;
                st_d    = ST_IDLE;
                ticks_d = '0;
              end
            end
            ST_EMERG: begin
              motor_d = 1'b0;
              servo_d = 1'b0;
              if (!pin_q) begin
                latch_d = 1'b0;
                st_d    = ST_IDLE;
              end
            end
            default: st_d = ST_IDLE;
          endcase
          // latched emergency always wins
          if (latch_d) st_d = ST_EMERG;
        end
        CMD_SAMPLE: begin
          if (sample_ok) begin
            if (cnt_inc >= CNT_W'(AVG_SAMPLES)) begin
              avg_d = quot[WEIGHT_W-1:0];
              sum_d = '0;
              cnt_d = '0;
            end else begin
              sum_d = sum_add;
              cnt_d = cnt_inc;
            end
          end
        end
        CMD_BOX: begin
          if (st_q == ST_MOVING && !latch_q) st_d = ST_BOX;
        end
        CMD_PRESS: begin
          if (press_q >= debounce_q) begin
            if (st_q == ST_IDLE && !latch_q) st_d = ST_MOVING;
            press_d = '0;
          end
        end
        CMD_PIN: begin
          pin_d = emerg_pin_pressed_i;
          if (emerg_pin_pressed_i) begin
            latch_d = 1'b1;
            st_d    = ST_EMERG;
          end
        end
        CMD_WRITE: begin
          last_cmd_d = data_byte_i;
          pend_d     = 1'b1;
        end
        CMD_READ: ;
        default: ;
      endcase
    end
  end

  // result run for this beat; status is taken after the event is applied
  always_comb begin
    pkt.state_code     = state_code(st_d);
    pkt.motor_on       = motor_d;
    pkt.servo_open     = servo_d;
    pkt.emergency_flag = latch_d;
    pkt.bytes          = '0;
    pkt.reply_valid    = 1'b0;
    pkt.last_idx       = '0;
    if (cmd_e'(cmd_i) == CMD_READ) begin
      pkt.reply_valid = 1'b1;
      unique case (last_cmd_q)
        OP_GET_WEIGHT: begin
          pkt.bytes[0] = avg_q[7:0];
          pkt.bytes[1] = 8'(avg_q[WEIGHT_W-1:8]);
          pkt.last_idx = BEAT_W'(3);
        end
        OP_GET_STATE: begin
          pkt.bytes[0] = 8'(state_code(st_q));
          pkt.bytes[1] = 8'(motor_q);
          pkt.bytes[2] = 8'(latch_q);
          pkt.last_idx = BEAT_W'(2);
        end
        OP_START, OP_STOP, OP_EMERG: pkt.bytes[0] = REPLY_ACK;
        default: pkt.bytes[0] = REPLY_UNKNOWN;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      motor_q    <= 1'b0;
      servo_q    <= 1'b0;
      latch_q    <= 1'b0;
      pin_q      <= 1'b0;
      ticks_q    <= '0;
      last_cmd_q <= '0;
      pend_q     <= 1'b0;
      sum_q      <= '0;
      cnt_q      <= '0;
      avg_q      <= '0;
      press_q    <= '1;
    end else begin
      st_q       <= st_d;
      motor_q    <= motor_d;
      servo_q    <= servo_d;
      latch_q    <= latch_d;
      pin_q      <= pin_d;
      ticks_q    <= ticks_d;
      last_cmd_q <= last_cmd_d;
      pend_q     <= pend_d;
      sum_q      <= sum_d;
      cnt_q      <= cnt_d;
      avg_q      <= avg_d;
      press_q    <= press_d;
    end
  end

  cfc_reply u_reply (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (accept),
    .pkt_i            (pkt),
    .ready_o          (ready),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .state_code_o     (state_code_o),
    .motor_on_o       (motor_on_o),
    .servo_open_o     (servo_open_o),
    .emergency_flag_o (emergency_flag_o),
    .reply_byte_o     (reply_byte_o),
    .reply_valid_o    (reply_valid_o),
    .reply_last_o     (reply_last_o)
  );

`ifndef SYNTHESIS
  a_cnt_below_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CNT_W'(AVG_SAMPLES))
    else $error("sample count reached group size without averaging");

  a_write_pends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_e'(cmd_i) == CMD_WRITE) |=> (pend_q && last_cmd_q == $past(data_byte_i)))
    else $error("i2c write did not leave a pending command");

  a_latch_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_e'(cmd_i) == CMD_TICK && latch_d) |=> st_q == ST_EMERG)
    else $error("latched emergency not in emergency state after tick");
`endif

endmodule
